// ----- hdl/tw_pkg.sv -----
// Package for the text window cell engine.
// Holds the command codes, register indexes and the payload structs of both channels.
// No dependencies.
`default_nettype none
package tw_pkg;
	localparam logic [3:0] OP_PUT     = 4'd0;
	localparam logic [3:0] OP_MOVE    = 4'd1;
	localparam logic [3:0] OP_INSCHAR = 4'd2;
	localparam logic [3:0] OP_CLREOL  = 4'd3;
	localparam logic [3:0] OP_CLRBOT  = 4'd4;
	localparam logic [3:0] OP_CLEAR   = 4'd5;
	localparam logic [3:0] OP_INSLINE = 4'd6;
	localparam logic [3:0] OP_DELLINE = 4'd7;
	localparam logic [3:0] OP_SCROLL  = 4'd8;
	localparam logic [3:0] OP_READ    = 4'd9;

	localparam logic [2:0] REG_COLS   = 3'd0;
	localparam logic [2:0] REG_ROWS   = 3'd1;
	localparam logic [2:0] REG_SCROLL = 3'd2;
	localparam logic [2:0] REG_BG     = 3'd3;
	localparam logic [2:0] REG_ATTR   = 3'd4;

	localparam logic [7:0]  RST_COLS   = 8'd80;
	localparam logic [6:0]  RST_ROWS   = 7'd25;
	localparam logic [15:0] RST_ATTR   = 16'd0;
	localparam logic [31:0] RST_BG     = 32'd32;

	typedef struct packed {
		logic [3:0] op;
		logic [7:0] char_code;
		logic [5:0] row;
		logic [6:0] column;
		logic [6:0] line_count;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [5:0]  cursor_row_out;
		logic [6:0]  cursor_col_out;
		logic [15:0] cell_data;
	} out_item_t;

	typedef struct packed {
		in_item_t item;
		logic     in_win;
	} cmd_t;
endpackage
`default_nettype wire

// ----- hdl/tw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module tw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/tw_front.sv -----
// Front end: accepts command words, checks the target position against the window
// and queues them in a two-entry queue for the back end. Depends on tw_pkg.
`default_nettype none
module tw_front import tw_pkg::*; #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire in_item_t                      in_item,
	input  wire logic                          hold,
	input  wire logic [$clog2(MAX_COLS+1)-1:0] w,
	input  wire logic [$clog2(MAX_ROWS+1)-1:0] h,
	output logic                               q_valid,
	output cmd_t                               q_cmd,
	input  wire logic                          q_pop
);
	cmd_t       ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cls;

	always_comb begin
		cls.item   = in_item;
		cls.in_win = (32'(in_item.row) < 32'(h)) && (32'(in_item.column) < 32'(w));
	end

	assign in_ready = (count_q != 2'd2) && !hold;
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hdl/tw_back.sv -----
// Back end: executes queued commands on the cell store one cell at a time and
// holds the cursor and the result register. Depends on tw_pkg and tw_ram.
`default_nettype none
module tw_back import tw_pkg::*; #(
	parameter int MAX_COLS  = 128,
	parameter int MAX_ROWS  = 64,
	parameter int CELL_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire cmd_t                          q_cmd,
	output logic                               q_pop,
	input  wire logic [$clog2(MAX_COLS+1)-1:0] w,
	input  wire logic [$clog2(MAX_ROWS+1)-1:0] h,
	input  wire logic                          scroll_en,
	input  wire logic [15:0]                   bg,
	input  wire logic [15:0]                   attr,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output out_item_t                          out_item,
	output logic                               clearing
);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = $clog2(MAX_COLS);
	localparam int WW    = $clog2(MAX_COLS+1);
	localparam int HW    = $clog2(MAX_ROWS+1);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_CRD  = 4'd2;
	localparam logic [3:0] S_CWR  = 4'd3;
	localparam logic [3:0] S_BLK  = 4'd4;
	localparam logic [3:0] S_WR1  = 4'd5;
	localparam logic [3:0] S_RD   = 4'd6;
	localparam logic [3:0] S_RD2  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	localparam logic [1:0] CM_UP  = 2'd0;
	localparam logic [1:0] CM_DN  = 2'd1;
	localparam logic [1:0] CM_COL = 2'd2;

	localparam logic [31:0] RST_BG_W = RST_BG;

	logic [3:0]           state_q;
	logic [AW-1:0]        clr_q;
	logic [RW-1:0]        cur_r_q, r_q, endr_q, blk_r0_q, blk_end_q, wr_r_q;
	logic [CW-1:0]        cur_c_q, c_q, endc_q, blk_c0_q, wr_c_q;
	logic [HW-1:0]        off_q;
	logic [1:0]           cmode_q;
	logic                 blk_pend_q, wr_pend_q;
	logic [CELL_BITS-1:0] wr_val_q;
	logic                 res_status_q;
	logic [15:0]          res_data_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [RW-1:0]        cr, hm1, irow, su_top, su_endr, su_blk, src_r;
	logic [CW-1:0]        cc, wm1, icol, src_c;
	logic [HW-1:0]        nsat, su_n;
	logic                 su_copy;
	logic [31:0]          put_w, bg_w, rd_w;
	logic [CELL_BITS-1:0] put_val, bg_val, rd_data;
	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [CELL_BITS-1:0] wr_data;
	in_item_t             it;

	assign it = q_cmd.item;

	always_comb begin
		hm1   = RW'(h - HW'(1));
		wm1   = CW'(w - WW'(1));
		cr    = (32'(cur_r_q) >= 32'(h)) ? hm1 : cur_r_q;
		cc    = (32'(cur_c_q) >= 32'(w)) ? wm1 : cur_c_q;
		irow  = RW'(it.row);
		icol  = CW'(it.column);
		nsat  = (32'(it.line_count) > 32'(h)) ? h : HW'(it.line_count);
		su_top  = (it.op == OP_DELLINE) ? cr : '0;
		su_n    = (it.op == OP_SCROLL) ? nsat : HW'(1);
		su_copy = (32'(su_top) + 32'(su_n)) < 32'(h);
		su_endr = RW'(32'(h) - 32'(su_n) - 32'd1);
		su_blk  = RW'(32'(h) - 32'(su_n));
		put_w   = 32'(attr | 16'(it.char_code));
		put_val = put_w[CELL_BITS-1:0];
		bg_w    = 32'(bg);
		bg_val  = bg_w[CELL_BITS-1:0];
		rd_w    = 32'(rd_data);
	end

	// Source cell of one copy step, by copy direction.
	always_comb begin
		src_r = r_q;
		src_c = c_q;
		case (cmode_q)
			CM_UP:   src_r = RW'(32'(r_q) + 32'(off_q));
			CM_DN:   src_r = r_q - RW'(1);
			CM_COL:  src_c = c_q - CW'(1);
			default: src_r = r_q;
		endcase
	end

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign clearing = (state_q == S_CLR);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {r_q, c_q};
		wr_data = bg_val;
		rd_en   = 1'b0;
		rd_addr = {src_r, src_c};
		case (state_q)
			S_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = RST_BG_W[CELL_BITS-1:0];
			end
			S_IDLE: begin
				wr_en   = q_pop && (it.op == OP_PUT);
				wr_addr = {cr, cc};
				wr_data = put_val;
			end
			S_CRD: rd_en = 1'b1;
			S_CWR: begin
				wr_en   = 1'b1;
				wr_data = rd_data;
			end
			S_BLK: wr_en = 1'b1;
			S_WR1: begin
				wr_en   = 1'b1;
				wr_addr = {wr_r_q, wr_c_q};
				wr_data = wr_val_q;
			end
			S_RD: begin
				rd_en   = 1'b1;
				rd_addr = {r_q, c_q};
			end
			default: wr_en = 1'b0;
		endcase
	end

	tw_ram #(.WIDTH(CELL_BITS), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			wr_r_q   <= irow;
			wr_c_q   <= icol;
			wr_val_q <= put_val;
		end
		if (state_q == S_RD2) begin
			res_data_q <= rd_w[15:0];
		end else if (q_pop) begin
			res_data_q <= 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			cur_r_q      <= '0;
			cur_c_q      <= '0;
			r_q          <= '0;
			c_q          <= '0;
			endr_q       <= '0;
			endc_q       <= '0;
			blk_r0_q     <= '0;
			blk_c0_q     <= '0;
			blk_end_q    <= '0;
			off_q        <= '0;
			cmode_q      <= CM_UP;
			blk_pend_q   <= 1'b0;
			wr_pend_q    <= 1'b0;
			res_status_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						cur_r_q      <= cr;
						cur_c_q      <= cc;
						res_status_q <= 1'b0;
						blk_pend_q   <= 1'b0;
						wr_pend_q    <= 1'b0;
						state_q      <= S_OUT;
						case (it.op)
							OP_PUT: begin
								if (cc != wm1) begin
									cur_c_q <= cc + CW'(1);
								end else if (cr != hm1) begin
									cur_r_q <= cr + RW'(1);
									cur_c_q <= '0;
								end else if (scroll_en) begin
									cur_c_q    <= '0;
									blk_pend_q <= 1'b1;
									blk_r0_q   <= su_blk;
									blk_c0_q   <= '0;
									blk_end_q  <= hm1;
									r_q        <= su_copy ? '0 : su_blk;
									c_q        <= '0;
									endr_q     <= su_endr;
									off_q      <= su_n;
									cmode_q    <= CM_UP;
									state_q    <= su_copy ? S_CRD : S_BLK;
								end
							end
							OP_MOVE: begin
								if (q_cmd.in_win) begin
									cur_r_q <= irow;
									cur_c_q <= icol;
								end else begin
									res_status_q <= 1'b1;
								end
							end
							OP_INSCHAR: begin
								if (q_cmd.in_win) begin
									cur_r_q   <= irow;
									cur_c_q   <= icol;
									wr_pend_q <= 1'b1;
									r_q       <= irow;
									c_q       <= wm1;
									endc_q    <= icol + CW'(1);
									cmode_q   <= CM_COL;
									state_q   <= (icol != wm1) ? S_CRD : S_WR1;
								end else begin
									res_status_q <= 1'b1;
								end
							end
							OP_CLREOL: begin
								r_q       <= cr;
								c_q       <= cc;
								blk_end_q <= cr;
								state_q   <= S_BLK;
							end
							OP_CLRBOT: begin
								r_q       <= cr;
								c_q       <= cc;
								blk_end_q <= hm1;
								state_q   <= S_BLK;
							end
							OP_CLEAR: begin
								r_q       <= '0;
								c_q       <= '0;
								blk_end_q <= hm1;
								state_q   <= S_BLK;
							end
							OP_INSLINE: begin
								blk_pend_q <= 1'b1;
								blk_r0_q   <= cr;
								blk_c0_q   <= '0;
								blk_end_q  <= cr;
								r_q        <= (cr != hm1) ? hm1 : cr;
								c_q        <= '0;
								endr_q     <= cr + RW'(1);
								cmode_q    <= CM_DN;
								state_q    <= (cr != hm1) ? S_CRD : S_BLK;
							end
							OP_DELLINE, OP_SCROLL: begin
								if (su_n != '0) begin
									blk_pend_q <= 1'b1;
									blk_r0_q   <= su_blk;
									blk_c0_q   <= '0;
									blk_end_q  <= hm1;
									r_q        <= su_copy ? su_top : su_blk;
									c_q        <= '0;
									endr_q     <= su_endr;
									off_q      <= su_n;
									cmode_q    <= CM_UP;
									state_q    <= su_copy ? S_CRD : S_BLK;
								end
							end
							OP_READ: begin
								if (q_cmd.in_win) begin
									r_q     <= irow;
									c_q     <= icol;
									state_q <= S_RD;
								end else begin
									res_status_q <= 1'b1;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					state_q <= S_CRD;
					if (cmode_q == CM_COL) begin
						if (c_q == endc_q) begin
							state_q <= wr_pend_q ? S_WR1 : S_OUT;
						end else begin
							c_q <= c_q - CW'(1);
						end
					end else if (c_q != wm1) begin
						c_q <= c_q + CW'(1);
					end else if (r_q != endr_q) begin
						c_q <= '0;
						r_q <= (cmode_q == CM_UP) ? r_q + RW'(1) : r_q - RW'(1);
					end else begin
						// Copy done: the vacated rows are blanked next.
						r_q     <= blk_r0_q;
						c_q     <= blk_c0_q;
						state_q <= blk_pend_q ? S_BLK : S_OUT;
					end
				end
				S_BLK: begin
					if (c_q != wm1) begin
						c_q <= c_q + CW'(1);
					end else if (r_q != blk_end_q) begin
						c_q <= '0;
						r_q <= r_q + RW'(1);
					end else begin
						state_q <= wr_pend_q ? S_WR1 : S_OUT;
					end
				end
				S_WR1: state_q <= S_OUT;
				S_RD:  state_q <= S_RD2;
				S_RD2: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q          <= 1'b1;
						out_q.status         <= res_status_q;
						out_q.cursor_row_out <= 6'(cur_r_q);
						out_q.cursor_col_out <= 7'(cur_c_q);
						out_q.cell_data      <= res_data_q;
						state_q              <= S_IDLE;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = {out_q.status, out_q.cursor_row_out, out_q.cursor_col_out,
		res_data_q & {16{1'b0}} | out_q.cell_data};

`ifndef SYNTHESIS
	a_wr_row_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != S_CLR) |-> (32'(wr_addr[AW-1:CW]) < 32'(h)))
		else $error("cell write below the window");
	a_wr_col_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != S_CLR) |-> (32'(wr_addr[CW-1:0]) < 32'(w)))
		else $error("cell write right of the window");
	a_copy_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CWR) |-> ($past(state_q) == S_CRD))
		else $error("copy write without a read before it");
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result word loaded outside the output step");
`endif
endmodule
`default_nettype wire

// ----- hdl/text_window_cell_engine_unit.sv -----
// Text window cell engine: a cursor-addressed character-cell store with commands.
// Commands are executed one at a time; row and line commands copy the cells to be moved and
// then blank or write cells, and this cell-by-cell store sweep sets the rate. The two-entry
// front queue takes new command words, while it has room, as another command is executed.
// After reset all 2^(log2 rows + log2 cols) store cells (8192 at default sizes) are cleared to
// the reset background, and no command word is taken until that is done.
// Depends on tw_pkg, tw_front, tw_back and tw_ram.
`default_nettype none
module text_window_cell_engine_unit import tw_pkg::*; #(
	parameter int MAX_COLS  = 128,
	parameter int MAX_ROWS  = 64,
	parameter int CELL_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int WW = $clog2(MAX_COLS+1);
	localparam int HW = $clog2(MAX_ROWS+1);

	logic [7:0]    cols_q;
	logic [6:0]    rows_q;
	logic          scroll_q;
	logic [15:0]   bg_q;
	logic [15:0]   attr_q;
	logic [WW-1:0] w;
	logic [HW-1:0] h;
	logic          q_valid, q_pop, clearing;
	cmd_t          q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= RST_COLS;
			rows_q   <= RST_ROWS;
			scroll_q <= 1'b1;
			bg_q     <= RST_BG[15:0];
			attr_q   <= RST_ATTR;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLS:   cols_q   <= cfg_data[7:0];
				REG_ROWS:   rows_q   <= cfg_data[6:0];
				REG_SCROLL: scroll_q <= cfg_data[0];
				REG_BG:     bg_q     <= cfg_data;
				REG_ATTR:   attr_q   <= cfg_data;
				default:    scroll_q <= scroll_q;
			endcase
		end
	end

	// Zero sizes count as one, oversized ones as the store size.
	always_comb begin
		if (cols_q == 8'd0) begin
			w = WW'(1);
		end else if (32'(cols_q) > 32'(MAX_COLS)) begin
			w = WW'(MAX_COLS);
		end else begin
			w = WW'(cols_q);
		end
		if (rows_q == 7'd0) begin
			h = HW'(1);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			h = HW'(MAX_ROWS);
		end else begin
			h = HW'(rows_q);
		end
	end

	tw_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.hold     (clearing),
		.w        (w),
		.h        (h),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	tw_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .CELL_BITS(CELL_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.w         (w),
		.h         (h),
		.scroll_en (scroll_q),
		.bg        (bg_q),
		.attr      (attr_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.clearing  (clearing)
	);
endmodule
`default_nettype wire

// ----- tb/tw_checker.sv -----
// Checker for the text window cell engine: watches the command, result and register channels.
// Keeps its own copy of the window, cursor and registers and compares every result word.
// Depends on tw_pkg.
module tw_checker import tw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_item,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	out_item_t   expected_q[$];
	logic [15:0] screen[64][128];
	int          cur_row, cur_col;
	logic [7:0]  width_reg;
	logic [6:0]  height_reg;
	logic        scroll_on;
	logic [15:0] bg_reg, attr_reg;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic report(input string what, input int got, input int want);
		$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic blank(input int r, input int from, input int w);
		for (int c = from; c < w; c++) screen[r][c] = bg_reg;
	endtask

	task automatic lines_up(input int top, input int n, input int w, input int h);
		if (top >= h || n == 0) return;
		if (n > h - top) n = h - top;
		for (int r = top; r + n < h; r++)
			for (int c = 0; c < w; c++) screen[r][c] = screen[r + n][c];
		for (int r = h - n; r < h; r++) blank(r, 0, w);
	endtask

	task automatic window_command(input in_item_t cmd, output out_item_t res);
		int w, h, n;
		logic in_win;
		w = (width_reg == 0) ? 1 : (width_reg > 128) ? 128 : width_reg;
		h = (height_reg == 0) ? 1 : (height_reg > 64) ? 64 : height_reg;
		in_win = (cmd.row < h) && (cmd.column < w);
		res = '0;
		// A window that shrank pulls the cursor back inside first.
		if (cur_row >= h) cur_row = h - 1;
		if (cur_col >= w) cur_col = w - 1;
		case (cmd.op)
			OP_PUT: begin
				screen[cur_row][cur_col] = {8'd0, cmd.char_code} | attr_reg;
				cur_col++;
				if (cur_col >= w) begin
					cur_col = 0;
					cur_row++;
					if (cur_row >= h) begin
						if (scroll_on) lines_up(0, 1, w, h);
						else cur_col = w - 1;
						cur_row = h - 1;
					end
				end
			end
			OP_MOVE: begin
				if (in_win) begin
					cur_row = cmd.row;
					cur_col = cmd.column;
				end else res.status = 1'b1;
			end
			OP_INSCHAR: begin
				if (in_win) begin
					for (int c = w - 1; c > cmd.column; c--)
						screen[cmd.row][c] = screen[cmd.row][c - 1];
					screen[cmd.row][cmd.column] = {8'd0, cmd.char_code} | attr_reg;
					cur_row = cmd.row;
					cur_col = cmd.column;
				end else res.status = 1'b1;
			end
			OP_CLREOL: blank(cur_row, cur_col, w);
			OP_CLRBOT: begin
				blank(cur_row, cur_col, w);
				for (int r = cur_row + 1; r < h; r++) blank(r, 0, w);
			end
			OP_CLEAR: for (int r = 0; r < h; r++) blank(r, 0, w);
			OP_INSLINE: begin
				for (int r = h - 1; r > cur_row; r--)
					for (int c = 0; c < w; c++) screen[r][c] = screen[r - 1][c];
				blank(cur_row, 0, w);
			end
			OP_DELLINE: lines_up(cur_row, 1, w, h);
			OP_SCROLL: begin
				n = (cmd.line_count > h) ? h : cmd.line_count;
				lines_up(0, n, w, h);
			end
			OP_READ: begin
				if (in_win) res.cell_data = screen[cmd.row][cmd.column];
				else res.status = 1'b1;
			end
			default: ;
		endcase
		res.cursor_row_out = cur_row[5:0];
		res.cursor_col_out = cur_col[6:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int r = 0; r < 64; r++)
				for (int c = 0; c < 128; c++) screen[r][c] = RST_BG[15:0];
			cur_row = 0;
			cur_col = 0;
			width_reg = RST_COLS;
			height_reg = RST_ROWS;
			scroll_on = 1'b1;
			bg_reg = RST_BG[15:0];
			attr_reg = RST_ATTR;
			expected_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COLS:   width_reg = cfg_data[7:0];
					REG_ROWS:   height_reg = cfg_data[6:0];
					REG_SCROLL: scroll_on = cfg_data[0];
					REG_BG:     bg_reg = cfg_data;
					REG_ATTR:   attr_reg = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				window_command(in_item, want);
				expected_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result word", out_item, 0);
				end else begin
					want = expected_q.pop_front();
					if (out_item.status !== want.status)
						report("status", out_item.status, want.status);
					if (out_item.cursor_row_out !== want.cursor_row_out)
						report("cursor row", out_item.cursor_row_out, want.cursor_row_out);
					if (out_item.cursor_col_out !== want.cursor_col_out)
						report("cursor column", out_item.cursor_col_out, want.cursor_col_out);
					if (out_item.cell_data !== want.cell_data)
						report("cell data", out_item.cell_data, want.cell_data);
				end
			end
			pending = expected_q.size();
		end
	end
endmodule

// ----- tb/tb.sv -----
// Top of the text window cell engine testbench: clock, reset, commands and register writes.
// Instantiates text_window_cell_engine_unit and tw_checker; depends on tw_pkg.
module tb;
	import tw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	in_item_t    in_item;
	out_item_t   out_item;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          mismatches, pending;
	bit          calm;
	int          win_w, win_h;

	text_window_cell_engine_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tw_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("text_window_cell_engine_unit verification failed");
		$finish;
	end

	// Outside calm phases the result side stalls for a fresh random count before each word.
	initial begin
		out_ready = 1'b0;
		forever begin
			int stall;
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic in_item_t mk(logic [3:0] op, logic [7:0] ch, logic [5:0] r,
			logic [6:0] c, logic [6:0] n);
		in_item_t it;
		it.op = op;
		it.char_code = ch;
		it.row = r;
		it.column = c;
		it.line_count = n;
		return it;
	endfunction

	task automatic send(input in_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write.
	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	function automatic in_item_t random_cmd(bit light);
		int pick;
		logic [3:0] op;
		logic [5:0] r;
		logic [6:0] c, n;
		pick = $urandom_range(0, 99);
		if (pick < 45) op = OP_PUT;
		else if (pick < 60) op = OP_MOVE;
		else if (pick < 72) op = OP_READ;
		else if (pick < 78) op = OP_INSCHAR;
		else if (pick < 81) op = OP_CLREOL;
		else if (pick < 84) op = 4'($urandom_range(10, 15));
		else if (light) op = OP_PUT;
		else op = 4'($urandom_range(OP_CLRBOT, OP_SCROLL));
		// Most positions land inside the window so that commands take effect.
		r = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, win_h - 1)) : 6'($urandom);
		c = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, win_w - 1)) : 7'($urandom);
		n = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, win_h)) : 7'($urandom);
		return mk(op, 8'($urandom), r, c, n);
	endfunction

	task automatic run_phase(input logic [7:0] cols, input logic [6:0] rows,
			input logic scr, input logic [15:0] bg, input logic [15:0] attr,
			input int count, input bit light, input bit no_gaps);
		wait_idle();
		reg_write(REG_COLS, {8'd0, cols});
		reg_write(REG_ROWS, {9'd0, rows});
		reg_write(REG_SCROLL, {15'd0, scr});
		reg_write(REG_BG, bg);
		reg_write(REG_ATTR, attr);
		cfg_valid <= 1'b0;
		win_w = (cols == 0) ? 1 : (cols > 128) ? 128 : cols;
		win_h = (rows == 0) ? 1 : (rows > 64) ? 64 : rows;
		calm = no_gaps;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2 && count >= 80) wait_idle();
			send(random_cmd(light));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_COLS;
		cfg_data = '0;
		calm = 1'b0;
		win_w = RST_COLS;
		win_h = RST_ROWS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed commands in the reset window of 80 by 25.
		send(mk(OP_PUT, 8'h00, 0, 0, 0));
		send(mk(OP_PUT, 8'hFF, 0, 0, 0));
		send(mk(OP_MOVE, 0, 24, 79, 0));
		send(mk(OP_PUT, 8'h41, 0, 0, 0));
		send(mk(OP_MOVE, 0, 25, 0, 0));
		send(mk(OP_MOVE, 0, 0, 80, 0));
		send(mk(OP_INSCHAR, 8'h42, 2, 5, 0));
		send(mk(OP_INSCHAR, 8'h43, 63, 127, 0));
		send(mk(OP_MOVE, 0, 1, 3, 0));
		send(mk(OP_CLREOL, 0, 0, 0, 0));
		send(mk(OP_INSCHAR, 8'h44, 1, 79, 0));
		send(mk(OP_CLRBOT, 0, 0, 0, 0));
		send(mk(OP_INSLINE, 0, 0, 0, 0));
		send(mk(OP_DELLINE, 0, 0, 0, 0));
		send(mk(OP_SCROLL, 0, 0, 0, 0));
		send(mk(OP_SCROLL, 0, 0, 0, 1));
		send(mk(OP_SCROLL, 0, 0, 0, 127));
		send(mk(OP_READ, 0, 2, 5, 0));
		send(mk(OP_READ, 0, 24, 79, 0));
		send(mk(OP_READ, 0, 63, 127, 0));
		send(mk(OP_CLEAR, 0, 0, 0, 0));
		send(mk(4'd10, 0, 0, 0, 0));
		send(mk(4'd15, 8'hFF, 63, 127, 127));
		send(mk(OP_READ, 0, 0, 0, 0));

		run_phase(8, 4, 1, 16'h0720, 16'h0100, 60, 0, 0);
		run_phase(8, 4, 0, 16'hFFFF, 16'hFF00, 60, 0, 0);
		run_phase(1, 1, 1, 16'h0000, 16'h0000, 30, 0, 1);
		run_phase(0, 0, 0, 16'h1234, 16'hFFFF, 20, 0, 0);
		run_phase(128, 64, 1, 16'h0020, 16'h8000, 40, 1, 0);
		// A few row commands over the full-size window.
		send(mk(OP_MOVE, 0, 0, 0, 0));
		send(mk(OP_INSLINE, 0, 0, 0, 0));
		send(mk(OP_DELLINE, 0, 0, 0, 0));
		send(mk(OP_SCROLL, 0, 0, 0, 64));
		send(mk(OP_MOVE, 0, 63, 127, 0));
		send(mk(OP_PUT, 8'h5A, 0, 0, 0));
		run_phase(255, 127, 0, 16'hAAAA, 16'h5555, 20, 1, 1);
		send(mk(OP_MOVE, 0, 63, 127, 0));
		send(mk(OP_PUT, 8'h5B, 0, 0, 0));
		run_phase(5, 3, 1, 16'($urandom), 16'($urandom), 60, 0, 0);
		run_phase(16, 8, 1'($urandom), 16'($urandom), 16'($urandom), 80, 0, 0);
		run_phase(3, 2, 1'($urandom), 16'($urandom), 16'($urandom), 30, 0, 0);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("text_window_cell_engine_unit verification clean");
		end else begin
			$display("text_window_cell_engine_unit verification failed");
		end
		$finish;
	end
endmodule
